### design/qrs_pkg.sv
// Package for the quadratic root solver.
// Holds the default widths and the root kind codes; no dependencies.
`timescale 1ns / 1ps

package qrs_pkg;

  localparam int unsigned COEF_WIDTH = 16;
  localparam int unsigned FRAC_BITS  = 16;

  // Widths of the result ports, fixed whatever the parameters.
  localparam int unsigned DISC_OUT_W = 34;
  localparam int unsigned ROOT_OUT_W = 48;

  localparam logic [1:0] KIND_REPEATED = 2'd0;
  localparam logic [1:0] KIND_TWO_REAL = 2'd1;
  localparam logic [1:0] KIND_COMPLEX  = 2'd2;
  localparam logic [1:0] KIND_A_ZERO   = 2'd3;

endpackage

### design/qrs_sqrt_stage.sv
// One stage of the pipelined square root: resolves one root bit from
// two radicand bits. No package dependencies.
`timescale 1ns / 1ps

module qrs_sqrt_stage #(
  parameter int unsigned RW     = 33,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [RW+1:0]     rem_i,
  input  logic [RW-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [2*RW-1:0]   rad_o,
  output logic [RW+1:0]     rem_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [RW+3:0]     rem_ext;
  logic [RW+3:0]     trial;
  logic [RW+1:0]     rem_d;
  logic [RW-1:0]     root_d;
  logic [2*RW-1:0]   rad_d;
  logic              valid_q;
  logic [2*RW-1:0]   rad_q;
  logic [RW+1:0]     rem_q;
  logic [RW-1:0]     root_q;
  logic [SIDE_W-1:0] side_q;

  always_comb begin
    rem_ext = {rem_i, rad_i[2*RW-1 -: 2]};
    trial   = {2'b00, root_i, 2'b01};
    rad_d   = rad_i << 2;
    if (rem_ext >= trial) begin
      rem_d  = (RW+2)'(rem_ext - trial);
      root_d = {root_i[RW-2:0], 1'b1};
    end else begin
      rem_d  = (RW+2)'(rem_ext);
      root_d = {root_i[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

### design/qrs_div_stage.sv
// One stage of the two-lane restoring divider: one quotient bit per lane.
// Both lanes share the divisor. No package dependencies.
`timescale 1ns / 1ps

module qrs_div_stage #(
  parameter int unsigned MW     = 34,
  parameter int unsigned DW     = 17,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [MW-1:0]     num1_i,
  input  logic [MW-1:0]     num2_i,
  input  logic [DW-1:0]     rem1_i,
  input  logic [DW-1:0]     rem2_i,
  input  logic [DW-1:0]     den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [MW-1:0]     num1_o,
  output logic [MW-1:0]     num2_o,
  output logic [DW-1:0]     rem1_o,
  output logic [DW-1:0]     rem2_o,
  output logic [DW-1:0]     den_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [DW:0]       ext1, ext2;
  logic [DW-1:0]     rem1_d, rem2_d;
  logic [MW-1:0]     num1_d, num2_d;
  logic              valid_q;
  logic [MW-1:0]     num1_q, num2_q;
  logic [DW-1:0]     rem1_q, rem2_q, den_q;
  logic [SIDE_W-1:0] side_q;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    ext1 = {rem1_i, num1_i[MW-1]};
    ext2 = {rem2_i, num2_i[MW-1]};
    if (ext1 >= {1'b0, den_i}) begin
      rem1_d = DW'(ext1 - {1'b0, den_i});
      num1_d = {num1_i[MW-2:0], 1'b1};
    end else begin
      rem1_d = DW'(ext1);
      num1_d = {num1_i[MW-2:0], 1'b0};
    end
    if (ext2 >= {1'b0, den_i}) begin
      rem2_d = DW'(ext2 - {1'b0, den_i});
      num2_d = {num2_i[MW-2:0], 1'b1};
    end else begin
      rem2_d = DW'(ext2);
      num2_d = {num2_i[MW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num1_q <= num1_d;
    num2_q <= num2_d;
    rem1_q <= rem1_d;
    rem2_q <= rem2_d;
    den_q  <= den_i;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign num1_o  = num1_q;
  assign num2_o  = num2_q;
  assign rem1_o  = rem1_q;
  assign rem2_o  = rem2_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

### design/quadratic_root_solver.sv
// Quadratic root solver: a start transfer passes through the product, discriminant,
// square root, numerator, divider and output registers before it reaches done_o.
// Throughput is one item per cycle; the square root and divider pipelines each
// resolve one bit per stage. busy is always low, since the receiver cannot stall.
// Reset clears all valid bits at once; payload registers are not reset.
// Depends on qrs_pkg, qrs_sqrt_stage and qrs_div_stage.
`timescale 1ns / 1ps

module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = qrs_pkg::COEF_WIDTH,
  parameter int unsigned FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COEF_WIDTH-1:0]         coef_a_i,
  input  logic signed [COEF_WIDTH-1:0]         coef_b_i,
  input  logic signed [COEF_WIDTH-1:0]         coef_c_i,
  output logic                                 done_o,
  output logic signed [qrs_pkg::DISC_OUT_W-1:0] discriminant_o,
  output logic [1:0]                           root_kind_o,
  output logic signed [qrs_pkg::ROOT_OUT_W-1:0] first_root_o,
  output logic signed [qrs_pkg::ROOT_OUT_W-1:0] second_root_o
);

  localparam int unsigned CW      = COEF_WIDTH;
  localparam int unsigned DISC_W  = 2*CW + 2;
  localparam int unsigned RW      = DISC_W/2 + FRAC_BITS;
  localparam int unsigned NUM_W   = CW + FRAC_BITS + 3;
  localparam int unsigned MW      = NUM_W - 1;
  localparam int unsigned DW      = CW + 1;
  localparam int unsigned SQ_SIDE = DISC_W + 2 + 2*CW;
  localparam int unsigned DV_SIDE = DISC_W + 4;
  localparam int unsigned LAT     = 4 + RW + MW;

  // Stage 1: products.
  logic                        v1_q;
  logic signed [CW-1:0]        a1_q, b1_q;
  logic signed [2*CW-1:0]      bb_q, ac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= coef_a_i;
    b1_q <= coef_b_i;
    bb_q <= coef_b_i * coef_b_i;
    ac_q <= coef_a_i * coef_c_i;
  end

  // Stage 2: discriminant and kind.
  logic signed [DISC_W-1:0] disc_d;
  logic [1:0]               kind_d;
  logic                     v2_q;
  logic signed [DISC_W-1:0] disc2_q;
  logic [1:0]               kind2_q;
  logic signed [CW-1:0]     a2_q, b2_q;

  always_comb begin
    disc_d = DISC_W'(bb_q) - (DISC_W'(ac_q) <<< 2);
    priority if (a1_q == '0) begin
      kind_d = qrs_pkg::KIND_A_ZERO;
    end else if (disc_d == '0) begin
      kind_d = qrs_pkg::KIND_REPEATED;
    end else if (!disc_d[DISC_W-1]) begin
      kind_d = qrs_pkg::KIND_TWO_REAL;
    end else begin
      kind_d = qrs_pkg::KIND_COMPLEX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    disc2_q <= disc_d;
    kind2_q <= kind_d;
    a2_q    <= a1_q;
    b2_q    <= b1_q;
  end

  // Square root pipeline over d * 4^FRAC_BITS.
  logic               sq_v    [0:RW];
  logic [2*RW-1:0]    sq_rad  [0:RW];
  logic [RW+1:0]      sq_rem  [0:RW];
  logic [RW-1:0]      sq_root [0:RW];
  logic [SQ_SIDE-1:0] sq_side [0:RW];

  assign sq_v[0]    = v2_q;
  assign sq_rad[0]  = {disc2_q[DISC_W-1:0], {(2*FRAC_BITS){1'b0}}};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {disc2_q, kind2_q, a2_q, b2_q};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    qrs_sqrt_stage #(
      .RW     (RW),
      .SIDE_W (SQ_SIDE)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_v[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // Numerator stage: signed numerators reduced to magnitudes and signs.
  logic signed [DISC_W-1:0] sq_disc;
  logic [1:0]               sq_kind;
  logic signed [CW-1:0]     sq_a, sq_b;
  logic signed [NUM_W-1:0]  nb, s_ext, num1, num2;
  logic signed [CW+1:0]     den2;
  logic                     vn_q;
  logic [MW-1:0]            mag1_q, mag2_q;
  logic [DW-1:0]            den_q;
  logic [DV_SIDE-1:0]       nside_q;

  always_comb begin
    {sq_disc, sq_kind, sq_a, sq_b} = sq_side[RW];
    nb    = -(NUM_W'(sq_b) <<< FRAC_BITS);
    s_ext = NUM_W'(sq_root[RW]);
    num1  = nb + s_ext;
    num2  = nb - s_ext;
    den2  = (CW+2)'(sq_a) <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else begin
      vn_q <= sq_v[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    mag1_q  <= MW'(num1[NUM_W-1] ? -num1 : num1);
    mag2_q  <= MW'(num2[NUM_W-1] ? -num2 : num2);
    den_q   <= DW'(den2[CW+1] ? -den2 : den2);
    nside_q <= {sq_disc, sq_kind,
                num1[NUM_W-1] ^ sq_a[CW-1], num2[NUM_W-1] ^ sq_a[CW-1]};
  end

  // Divider pipeline, both roots side by side.
  logic               dv_v    [0:MW];
  logic [MW-1:0]      dv_num1 [0:MW];
  logic [MW-1:0]      dv_num2 [0:MW];
  logic [DW-1:0]      dv_rem1 [0:MW];
  logic [DW-1:0]      dv_rem2 [0:MW];
  logic [DW-1:0]      dv_den  [0:MW];
  logic [DV_SIDE-1:0] dv_side [0:MW];

  assign dv_v[0]    = vn_q;
  assign dv_num1[0] = mag1_q;
  assign dv_num2[0] = mag2_q;
  assign dv_rem1[0] = '0;
  assign dv_rem2[0] = '0;
  assign dv_den[0]  = den_q;
  assign dv_side[0] = nside_q;

  for (genvar j = 0; j < MW; j++) begin : g_div
    qrs_div_stage #(
      .MW     (MW),
      .DW     (DW),
      .SIDE_W (DV_SIDE)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[j]),
      .num1_i  (dv_num1[j]),
      .num2_i  (dv_num2[j]),
      .rem1_i  (dv_rem1[j]),
      .rem2_i  (dv_rem2[j]),
      .den_i   (dv_den[j]),
      .side_i  (dv_side[j]),
      .valid_o (dv_v[j+1]),
      .num1_o  (dv_num1[j+1]),
      .num2_o  (dv_num2[j+1]),
      .rem1_o  (dv_rem1[j+1]),
      .rem2_o  (dv_rem2[j+1]),
      .den_o   (dv_den[j+1]),
      .side_o  (dv_side[j+1])
    );
  end

  // Output stage: apply signs, zero the roots outside the real cases.
  logic signed [DISC_W-1:0] dv_disc;
  logic [1:0]               dv_kind;
  logic                     neg1, neg2;
  logic signed [MW:0]       q1s, q2s;
  logic                     done_q;
  logic signed [qrs_pkg::DISC_OUT_W-1:0] disc_q;
  logic [1:0]                            kind_q;
  logic signed [qrs_pkg::ROOT_OUT_W-1:0] r1_q, r2_q;

  always_comb begin
    {dv_disc, dv_kind, neg1, neg2} = dv_side[MW];
    q1s = neg1 ? -$signed({1'b0, dv_num1[MW]}) : $signed({1'b0, dv_num1[MW]});
    q2s = neg2 ? -$signed({1'b0, dv_num2[MW]}) : $signed({1'b0, dv_num2[MW]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v[MW];
    end
  end

  always_ff @(posedge clk_i) begin
    disc_q <= qrs_pkg::DISC_OUT_W'(dv_disc);
    kind_q <= dv_kind;
    if (dv_kind == qrs_pkg::KIND_REPEATED || dv_kind == qrs_pkg::KIND_TWO_REAL) begin
      r1_q <= qrs_pkg::ROOT_OUT_W'(q1s);
      r2_q <= qrs_pkg::ROOT_OUT_W'(q2s);
    end else begin
      r1_q <= '0;
      r2_q <= '0;
    end
  end

  assign busy           = 1'b0;
  assign done_o         = done_q;
  assign discriminant_o = disc_q;
  assign root_kind_o    = kind_q;
  assign first_root_o   = r1_q;
  assign second_root_o  = r2_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT done_o)
    else $error("result strobe did not follow a start transfer");

  a_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##LAT !done_o)
    else $error("result strobe without a start transfer");

  a_zero_roots : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (root_kind_o == qrs_pkg::KIND_COMPLEX ||
                root_kind_o == qrs_pkg::KIND_A_ZERO))
      |-> (first_root_o == '0 && second_root_o == '0))
    else $error("roots not zero for a complex or degenerate result");

  a_repeated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && root_kind_o == qrs_pkg::KIND_REPEATED)
      |-> (first_root_o == second_root_o))
    else $error("repeated root reported with two different roots");

endmodule

### bench/qrs_checker.sv
// Checker for the quadratic root solver: watches the start and done transfers,
// predicts each result and compares it field by field. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic signed [15:0]  coef_a_i,
  input  logic signed [15:0]  coef_b_i,
  input  logic signed [15:0]  coef_c_i,
  input  logic                done_i,
  input  logic signed [33:0]  discriminant_i,
  input  logic [1:0]          root_kind_i,
  input  logic signed [47:0]  first_root_i,
  input  logic signed [47:0]  second_root_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic signed [33:0] disc;
    logic [1:0]         kind;
    logic signed [47:0] r1;
    logic signed [47:0] r2;
  } solution_t;

  solution_t solutions_q[$];

  // Integer square root of d * 2^32, two radicand bits per step.
  function automatic longint unsigned scaled_sqrt(longint unsigned d);
    longint unsigned rem, root, trial;
    rem  = 0;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((d >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    for (int i = 0; i < 16; i++) begin
      rem   = rem << 2;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic solution_t predict_solution(logic signed [15:0] a,
                                                 logic signed [15:0] b,
                                                 logic signed [15:0] c);
    solution_t s;
    longint d, sq, nb, den;
    d = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
    s.disc = d[33:0];
    s.r1 = '0;
    s.r2 = '0;
    if (a == 0) s.kind = qrs_pkg::KIND_A_ZERO;
    else if (d == 0) s.kind = qrs_pkg::KIND_REPEATED;
    else if (d > 0) s.kind = qrs_pkg::KIND_TWO_REAL;
    else s.kind = qrs_pkg::KIND_COMPLEX;
    if (s.kind == qrs_pkg::KIND_REPEATED || s.kind == qrs_pkg::KIND_TWO_REAL) begin
      sq  = longint'(scaled_sqrt(d));
      nb  = -longint'(b) * 65536;
      den = 2 * longint'(a);
      s.r1 = 48'((nb + sq) / den);
      s.r2 = 48'((nb - sq) / den);
    end
    return s;
  endfunction

  initial fail_count_o = 0;
  assign pending_o = solutions_q.size();

  always @(posedge clk_i) begin
    solution_t want;
    int errs;
    errs = 0;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        solutions_q.push_back(predict_solution(coef_a_i, coef_b_i, coef_c_i));
      end
      if (done_i) begin
        if (solutions_q.size() == 0) begin
          $error("result with no transfer waiting");
          errs = errs + 1;
        end else begin
          want = solutions_q.pop_front();
          if (discriminant_i !== want.disc) begin
            $error("discriminant: expected %0d, got %0d", want.disc, discriminant_i);
            errs = errs + 1;
          end
          if (root_kind_i !== want.kind) begin
            $error("root_kind: expected %0d, got %0d", want.kind, root_kind_i);
            errs = errs + 1;
          end
          if (first_root_i !== want.r1) begin
            $error("first_root: expected %0d, got %0d", want.r1, first_root_i);
            errs = errs + 1;
          end
          if (second_root_i !== want.r2) begin
            $error("second_root: expected %0d, got %0d", want.r2, second_root_i);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

### bench/quadratic_root_solver_tb.sv
// Top of the quadratic root solver bench: drives coefficient sets and gives the verdict.
// Depends on qrs_pkg, quadratic_root_solver and qrs_checker.
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] coef_a = '0, coef_b = '0, coef_c = '0;
  logic done;
  logic signed [33:0] discriminant;
  logic [1:0] root_kind;
  logic signed [47:0] first_root, second_root;
  int fail_count, pending;
  int idle_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  quadratic_root_solver uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .coef_a_i(coef_a), .coef_b_i(coef_b), .coef_c_i(coef_c),
    .done_o(done), .discriminant_o(discriminant), .root_kind_o(root_kind),
    .first_root_o(first_root), .second_root_o(second_root)
  );

  qrs_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .coef_a_i(coef_a), .coef_b_i(coef_b), .coef_c_i(coef_c),
    .done_i(done), .discriminant_i(discriminant), .root_kind_i(root_kind),
    .first_root_i(first_root), .second_root_i(second_root),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: counts cycles without any transfer.
  always @(posedge clk_i) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("quadratic_root_solver_tb failed");
      $finish;
    end
  end

  // Offers one coefficient set, gapping first with the given percentage.
  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c, int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly small or well-formed coefficients, with full-range values now and then.
  function automatic logic signed [15:0] pick_coef();
    unique case ($urandom_range(5))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2: return '0;
      default: return 16'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  task automatic send_random(int count, int gap_pct);
    logic signed [15:0] a, b, r;
    for (int i = 0; i < count; i++) begin
      a = pick_coef();
      b = pick_coef();
      if ($urandom_range(3) == 0) begin
        // Choose b and c so that r is a repeated root, unless the products wrap.
        r = 16'($signed($urandom_range(20)) - 10);
        b = 16'(-2 * a * r);
        send_coefs(a, b, 16'(a * r * r), gap_pct);
      end else begin
        send_coefs(a, b, pick_coef(), gap_pct);
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Extremes, repeated roots, complex roots and a equal to zero.
    send_coefs(16'sh7fff, 16'sh8000, 16'sh8000, 0);
    send_coefs(16'sh8000, 16'sh8000, 16'sh7fff, 0);
    send_coefs(16'sh8000, 16'sh7fff, 16'sh8000, 0);
    send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_coefs(16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_coefs(16'sh0001, 16'sh0002, 16'sh0001, 0);
    send_coefs(16'sh0001, -16'sh0004, 16'sh0004, 0);
    send_coefs(-16'sh0003, 16'sh0001, 16'sh0000, 0);
    send_coefs(16'sh0001, 16'sh0000, 16'sh0001, 0);
    send_coefs(16'sh0001, 16'sh0000, -16'sh0002, 0);
    send_coefs(16'sh0000, 16'sh0005, 16'sh0003, 0);
    send_coefs(16'sh0000, 16'sh8000, 16'sh7fff, 0);
    send_coefs(16'sh0000, 16'sh0000, 16'sh0000, 0);
    send_coefs(16'sh0002, 16'sh0003, -16'sh0007, 0);
    send_coefs(-16'sh0001, 16'sh0000, 16'sh8000, 0);
    send_coefs(16'sh5555, 16'shaaaa, 16'sh5555, 0);
    start <= 1'b0;
    // Let the pipeline drain completely before the random part.
    while (pending != 0) @(negedge clk_i);
    send_random(230, 33);
    send_random(230, 83);
    send_random(240, 0);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) $display("quadratic_root_solver_tb passed");
    else $display("quadratic_root_solver_tb failed");
    $finish;
  end
endmodule
